// File: rtl/tdpt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdpt_pkg: shared types and constants of the trial-division prime test
// Number width, channel widths and the command/status bundles that pass
// between the sequencer and the serial remainder unit.
// ---------------------------------------------------------------------------
package tdpt_pkg;

   // Width of the number under test; the candidate is cut to this width
   localparam int NUMBER_WIDTH = 32;
   // Width of the candidate field on the input channel
   localparam int CAND_W       = 32;
   localparam int REQ_DATA_W   = ((CAND_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = 8;
   // Bit counter of the remainder unit holds NUMBER_WIDTH itself
   localparam int CNT_W        = $clog2(NUMBER_WIDTH + 1);
   // Running divisor square, with headroom for one step past the bound
   localparam int SQ_W         = NUMBER_WIDTH + 2;

   typedef logic [NUMBER_WIDTH-1:0] num_type;

   typedef struct packed {
      logic    start;
      num_type dividend;
      num_type divisor;
   } rem_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic zero;
   } rem_sts_type;

endpackage

// File: rtl/trial_division_prime_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Sequencer that walks odd divisors and drives one serial remainder unit.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one candidate per beat (tdata[31:0]); rsp_* returns one
//   beat per candidate with is_prime in tdata[0].
//   Zero, one and even candidates are settled at once, without a division.
//   An odd candidate n is divided by 3, 5, 7, ... while the divisor squared
//   does not exceed n; each divisor goes through a bound check, a serial
//   remainder and a decision, so large primes take longest. A composite
//   stops at its smallest odd factor.
//   req_tready is high only while the block is idle; one candidate is in
//   work at a time.
//   The result sits in an output register; a new candidate is taken while
//   it waits. If the receiver stalls, a finished result waits in its own
//   state until the output register frees.
//   Reset (synchronous, active high) drops any work and any pending result.
// ---------------------------------------------------------------------------
module trial_division_prime_test (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tdpt_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] candidate
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tdpt_pkg::RSP_DATA_W-1:0] rsp_tdata   // [0] is_prime, [7:1] zero
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type                  state_ff, state_in;
   tdpt_pkg::num_type          n_ff, n_in;
   tdpt_pkg::num_type          div_ff, div_in;
   logic [tdpt_pkg::SQ_W-1:0]  sq_ff, sq_in;
   logic                       res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_bit_ff, rsp_bit_in;
   tdpt_pkg::num_type          cand;
   logic                       req_fire;
   tdpt_pkg::rem_cmd_type      rem_cmd;
   tdpt_pkg::rem_sts_type      rem_sts;

   assign cand     = tdpt_pkg::NUMBER_WIDTH'(req_tdata[tdpt_pkg::CAND_W-1:0]);
   assign req_fire = req_tvalid && req_tready;

   tdpt_rem_unit u_rem (
      .clock (clock),
      .reset (reset),
      .cmd   (rem_cmd),
      .sts   (rem_sts)
   );

   // Sequencer: screen, bound check, divide, advance divisor, hand over the result
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      div_in        = div_ff;
      sq_in         = sq_ff;
      res_in        = res_ff;
      rsp_bit_in    = rsp_bit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rem_cmd.start    = 1'b0;
      rem_cmd.dividend = n_ff;
      rem_cmd.divisor  = div_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               n_in = cand;
               if (cand < tdpt_pkg::NUMBER_WIDTH'(2) || !cand[0]) begin
                  res_in   = (cand == tdpt_pkg::NUMBER_WIDTH'(2));
                  state_in = ST_DONE;
               end else begin
                  div_in   = tdpt_pkg::NUMBER_WIDTH'(3);
                  sq_in    = tdpt_pkg::SQ_W'(9);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sq_ff > {2'b00, n_ff}) begin
               res_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               rem_cmd.start = 1'b1;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rem_sts.done) begin
               if (rem_sts.zero) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  // (d + 2)^2 = d^2 + 4d + 4
                  div_in   = div_ff + tdpt_pkg::NUMBER_WIDTH'(2);
                  sq_in    = sq_ff + {div_ff, 2'b00} + tdpt_pkg::SQ_W'(4);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            // Hand the result over once the output register frees
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_bit_in   = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff       <= n_in;
      div_ff     <= div_in;
      sq_ff      <= sq_in;
      res_ff     <= res_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tdpt_pkg::RSP_DATA_W-1){1'b0}}, rsp_bit_ff};

`ifndef SYNTHESIS
   // The remainder unit is only started while it is free
   a_start_free : assert property (@(posedge clock) disable iff (reset)
      rem_cmd.start |-> !rem_sts.busy)
      else $error("remainder unit started while busy");

   // Divisors under test are always odd
   a_div_odd : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> div_ff[0])
      else $error("even divisor under test");

   // Even candidates other than two are screened out as composite at once
   a_even_screen : assert property (@(posedge clock) disable iff (reset)
      (req_fire && !cand[0] && cand != tdpt_pkg::NUMBER_WIDTH'(2))
      |=> (state_ff == ST_DONE) && !res_ff)
      else $error("even candidate not screened");

   // A finished result is never dropped while the output register is held
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_bit_ff))
      else $error("pending result overwritten");
`endif

endmodule

// File: rtl/tdpt_rem_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tdpt_rem_unit: serial remainder unit
// Restoring division, one dividend bit per cycle; a start is taken only
// while idle. Pulses done with a flag that tells whether the remainder is 0.
// ---------------------------------------------------------------------------
module tdpt_rem_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  tdpt_pkg::rem_cmd_type cmd,
   output tdpt_pkg::rem_sts_type sts
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        zero_ff, zero_in;
   logic [tdpt_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   tdpt_pkg::num_type           rem_ff, rem_in;
   tdpt_pkg::num_type           shift_ff, shift_in;
   tdpt_pkg::num_type           div_ff, div_in;
   logic [tdpt_pkg::NUMBER_WIDTH:0] trial;
   logic [tdpt_pkg::NUMBER_WIDTH:0] diff;

   // Shift the next dividend bit in and trial-subtract the divisor
   assign trial = {rem_ff, shift_ff[tdpt_pkg::NUMBER_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      zero_in  = zero_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      if (busy_ff) begin
         // Restore when the subtraction went negative
         rem_in   = diff[tdpt_pkg::NUMBER_WIDTH] ?
                    trial[tdpt_pkg::NUMBER_WIDTH-1:0] :
                    diff[tdpt_pkg::NUMBER_WIDTH-1:0];
         shift_in = {shift_ff[tdpt_pkg::NUMBER_WIDTH-2:0], 1'b0};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == tdpt_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            zero_in = (rem_in == '0);
         end
      end else if (cmd.start) begin
         // Load a new operation
         busy_in  = 1'b1;
         cnt_in   = tdpt_pkg::CNT_W'(tdpt_pkg::NUMBER_WIDTH);
         rem_in   = '0;
         shift_in = cmd.dividend;
         div_in   = cmd.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         zero_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         zero_ff <= zero_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.zero = zero_ff;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for trial_division_prime_test
// Feeds candidates over the req stream and predicts the primality verdict of
// each one by trial division. A checker compares every rsp beat with the
// oldest pending verdict. Directed corners come first: zero, one, two, evens,
// odd squares and the widest values. A receiver hold-off follows, then random
// candidates under three sender/receiver idling mixes. Most candidates stay
// small, because large primes are slow to test.
// ---------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_PERIOD   = 10;
   localparam int STALL_LIMIT    = 500000;
   localparam int DRAIN_CYCLES   = 50;
   localparam int REPORT_LIMIT   = 10;
   localparam int HOLD_OFF_LEN   = 2000;

   typedef struct {
      logic [tdpt_pkg::CAND_W-1:0] candidate;
      logic                        is_prime;
   } verdict_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tdpt_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // [31:0] candidate
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tdpt_pkg::RSP_DATA_W-1:0] rsp_tdata;        // [0] is_prime

   verdict_type pending_verdicts[$];
   int          mismatch_count = 0;
   int          stall_cycles   = 0;
   int          send_idle_pct  = 0;
   int          recv_idle_pct  = 0;
   int          hold_request   = 0;
   int          hold_left      = 0;

   trial_division_prime_test dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Trial division over odd divisors, candidate cut to the number width
   function automatic logic predict_is_prime(input logic [tdpt_pkg::CAND_W-1:0] candidate);
      longint unsigned n;
      longint unsigned d;
      n = 64'(candidate);
      if (tdpt_pkg::NUMBER_WIDTH < 64)
         n = n & ((64'd1 << tdpt_pkg::NUMBER_WIDTH) - 64'd1);
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      if ((n & 64'd1) == 0) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%t mismatch: %s", $realtime, what);
   endtask

   // Offer one candidate, hold it until the beat is taken, then log its verdict
   task automatic send_candidate(input logic [tdpt_pkg::CAND_W-1:0] candidate);
      verdict_type verdict;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tdpt_pkg::REQ_DATA_W'(candidate);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      verdict.candidate = candidate;
      verdict.is_prime  = predict_is_prime(candidate);
      pending_verdicts.push_back(verdict);
   endtask

   // Drive the receiver: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Check each rsp beat against the oldest pending verdict; track stalls
   always @(posedge clock) begin
      verdict_type oldest;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               note_mismatch($sformatf("result beat 0x%02h with no candidate pending",
                                       rsp_tdata));
            end else begin
               oldest = pending_verdicts.pop_front();
               if (rsp_tdata[0] !== oldest.is_prime)
                  note_mismatch($sformatf("candidate %0d: is_prime expected %0b, got %0b",
                                          oldest.candidate, oldest.is_prime, rsp_tdata[0]));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   // Watchdog: end the run when no beat moves for too long
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   // Zero, one, two, evens and small odd numbers, squares among them
   task automatic test_special_cases();
      send_candidate(32'd0);
      send_candidate(32'd1);
      send_candidate(32'd2);
      send_candidate(32'd3);
      send_candidate(32'd4);
      send_candidate(32'd5);
      send_candidate(32'd9);
      send_candidate(32'd15);
      send_candidate(32'd25);
      send_candidate(32'd49);
      send_candidate(32'd97);
   endtask

   // Widest values, alternating bit patterns, larger primes and a prime square
   task automatic test_extremes();
      send_candidate(32'hFFFF_FFFF);
      send_candidate(32'hFFFF_FFFE);
      send_candidate(32'h8000_0000);
      send_candidate(32'hAAAA_AAAA);
      send_candidate(32'h5555_5555);
      send_candidate(32'd65521);
      send_candidate(32'd65535);
      send_candidate(32'd16752649);
      send_candidate(32'd16777213);
   endtask

   // Stall the receiver long enough for the block to back up into req
   task automatic test_backpressure();
      int i;
      hold_request = HOLD_OFF_LEN;
      for (i = 0; i < 5; i++) send_candidate(32'($urandom_range(2, 200)));
   endtask

   // Mostly small candidates; wide ones are made multiples of 15 to stay fast
   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      int                          i;
      int                          pick;
      logic [tdpt_pkg::CAND_W-1:0] candidate;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            candidate = 32'($urandom_range(0, 4095));
         end else if (pick < 8) begin
            candidate = 32'($urandom_range(0, 1 << 18));
         end else begin
            candidate = $urandom;
            candidate = candidate - (candidate % 15);
         end
         send_candidate(candidate);
      end
   endtask

   initial begin
      send_idle_pct = 15;
      recv_idle_pct = 51;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      test_extremes();
      test_backpressure();
      test_random(25, 15, 51);
      test_random(25, 51, 15);
      test_random(25, 0, 0);

      // Drop valid and drain every outstanding verdict
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
